@@ design/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, item types and slot codes for the rotation matrix to
// quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int FIELD_W   = 16;
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int LANES     = 4;

  // square-root argument, signed, with headroom for three diagonal terms
  localparam int ARG_W     = ((FRAC_BITS > 16) ? FRAC_BITS : 17) + 2;
  localparam int RAD_W     = 2 * ((ARG_W - 1 + FRAC_BITS + 1) / 2);
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SQ_REM_W  = ROOT_W + 3;

  // off-diagonal sums and differences
  localparam int D_W       = FIELD_W + 1;
  localparam int DMAG_W    = FIELD_W + 1;

  // divider: numerator, denominator and quotient widths
  localparam int NUM_W     = DMAG_W + FRAC_BITS + 1;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int QUO_W     = NUM_W - FRAC_BITS / 2 - 1;
  localparam int DV_REM_W  = DEN_W + 1;

  localparam int CMP_W     = 40;

  typedef enum logic [1:0] {
    SLOT_W = 2'd0,
    SLOT_X = 2'd1,
    SLOT_Y = 2'd2,
    SLOT_Z = 2'd3
  } slot_e;

  typedef struct packed {
    logic signed [FIELD_W-1:0] xa_x;
    logic signed [FIELD_W-1:0] xa_y;
    logic signed [FIELD_W-1:0] xa_z;
    logic signed [FIELD_W-1:0] ya_x;
    logic signed [FIELD_W-1:0] ya_y;
    logic signed [FIELD_W-1:0] ya_z;
    logic signed [FIELD_W-1:0] za_x;
    logic signed [FIELD_W-1:0] za_y;
    logic signed [FIELD_W-1:0] za_z;
  } rmq_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] q_w;
    logic signed [FIELD_W-1:0] q_x;
    logic signed [FIELD_W-1:0] q_y;
    logic signed [FIELD_W-1:0] q_z;
    logic                      degenerate;
  } rmq_out_t;

  // sideband that travels beside the square root
  typedef struct packed {
    logic                        deg;
    slot_e                       sel;
    logic [LANES-1:0][D_W-1:0]   d;
  } rmq_side_t;

  // sideband that travels beside the divider
  typedef struct packed {
    logic                        deg;
    slot_e                       sel;
    logic [LANES-1:0]            neg;
    logic [ROOT_W-1:0]           root;
  } rmq_dside_t;

endpackage

@@ design/rmq_front.sv @@
// ----------------------------------------------------------------------------
// rmq_front
// Trace, pivot choice, square-root argument and off-diagonal terms.
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  rmq_in_t           data_i,
  output logic              valid_o,
  output logic [RAD_W-1:0]  rad_o,
  output rmq_side_t         side_o
);

  logic signed [ARG_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [ARG_W-1:0] trace, arg, one;
  logic                    pos, big1;
  slot_e                   piv;
  rmq_side_t               side_d, side_q;
  logic [RAD_W-1:0]        rad_d, rad_q;
  logic                    valid_q;

  assign m00 = ARG_W'(data_i.xa_x);
  assign m10 = ARG_W'(data_i.xa_y);
  assign m20 = ARG_W'(data_i.xa_z);
  assign m01 = ARG_W'(data_i.ya_x);
  assign m11 = ARG_W'(data_i.ya_y);
  assign m21 = ARG_W'(data_i.ya_z);
  assign m02 = ARG_W'(data_i.za_x);
  assign m12 = ARG_W'(data_i.za_y);
  assign m22 = ARG_W'(data_i.za_z);
  assign one = ARG_W'(ONE_Q);

  always_comb begin
    trace = m00 + m11 + m22;
    pos   = (trace > 0);
    big1  = (m11 > m00);
    piv   = big1 ? SLOT_Y : SLOT_X;
    if (m22 > (big1 ? m11 : m00)) begin
      piv = SLOT_Z;
    end
    side_d   = '0;
    if (pos) begin
      side_d.sel  = SLOT_W;
      arg         = trace + one;
      side_d.d[1] = D_W'(m21 - m12);
      side_d.d[2] = D_W'(m02 - m20);
      side_d.d[3] = D_W'(m10 - m01);
    end else begin
      side_d.sel = piv;
      unique case (piv)
        SLOT_X: begin
          arg         = m00 - m11 - m22 + one;
          side_d.d[0] = D_W'(m21 - m12);
          side_d.d[2] = D_W'(m10 + m01);
          side_d.d[3] = D_W'(m20 + m02);
        end
        SLOT_Y: begin
          arg         = m11 - m22 - m00 + one;
          side_d.d[0] = D_W'(m02 - m20);
          side_d.d[3] = D_W'(m21 + m12);
          side_d.d[1] = D_W'(m01 + m10);
        end
        default: begin
          arg         = m22 - m00 - m11 + one;
          side_d.d[0] = D_W'(m10 - m01);
          side_d.d[1] = D_W'(m02 + m20);
          side_d.d[2] = D_W'(m12 + m21);
        end
      endcase
    end
    side_d.deg = !pos && (arg[ARG_W-1] || (arg == '0));
    rad_d      = RAD_W'(arg[ARG_W-2:0]) << FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      rad_q  <= rad_d;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

@@ design/rmq_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt import rmq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  rmq_side_t         side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output rmq_side_t         side_o
);

  logic                    v_q    [ROOT_W];
  logic [RAD_W-1:0]        rad_q  [ROOT_W];
  logic [SQ_REM_W-1:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0]       root_q [ROOT_W];
  rmq_side_t               side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    logic                v_in;
    logic [RAD_W-1:0]    rad_in;
    logic [SQ_REM_W-1:0] rem_in, rem_sh, trial, rem_d;
    logic [ROOT_W-1:0]   root_in, root_d;
    rmq_side_t           side_in;
    logic                ge;

    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_body
      assign v_in    = v_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[SQ_REM_W-3:0], rad_in[RAD_W-1 -: 2]};
      trial  = SQ_REM_W'({root_in, 2'b01});
      ge     = (rem_sh >= trial);
      rem_d  = ge ? (rem_sh - trial) : rem_sh;
      root_d = {root_in[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

@@ design/rmq_div.sv @@
// ----------------------------------------------------------------------------
// rmq_div
// Operand preparation and four-lane pipelined restoring divider.
// ----------------------------------------------------------------------------
module rmq_div import rmq_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [ROOT_W-1:0]            root_i,
  input  rmq_side_t                    side_i,
  output logic                         valid_o,
  output logic [LANES-1:0][QUO_W-1:0]  quo_o,
  output rmq_dside_t                   dside_o
);

  // preparation stage
  logic                          pv_q;
  logic [LANES-1:0][NUM_W-1:0]   pnum_d, pnum_q;
  rmq_dside_t                    pds_d, pds_q;

  always_comb begin
    logic signed [D_W-1:0] dv;
    logic [DMAG_W-1:0]     mag;
    pds_d.deg  = side_i.deg;
    pds_d.sel  = side_i.sel;
    pds_d.root = root_i;
    pds_d.neg  = '0;
    pnum_d     = '0;
    for (int l = 0; l < LANES; l++) begin
      dv           = $signed(side_i.d[l]);
      pds_d.neg[l] = dv[D_W-1];
      mag          = dv[D_W-1] ? DMAG_W'(-dv) : DMAG_W'(dv);
      pnum_d[l]    = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(root_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pnum_q <= pnum_d;
      pds_q  <= pds_d;
    end
  end

  // division stages, one quotient bit each
  logic                           v_q   [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]    num_q [QUO_W];
  logic [LANES-1:0][DV_REM_W-1:0] rem_q [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]    quo_q [QUO_W];
  rmq_dside_t                     ds_q  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_st
    logic                           v_in;
    logic [LANES-1:0][QUO_W-1:0]    num_in, num_d, quo_in, quo_d;
    logic [LANES-1:0][DV_REM_W-1:0] rem_in, rem_d;
    rmq_dside_t                     ds_in;

    if (k == 0) begin : g_head
      assign v_in   = pv_q;
      assign ds_in  = pds_q;
      assign quo_in = '0;
      for (genvar l = 0; l < LANES; l++) begin : g_ln
        assign num_in[l] = pnum_q[l][QUO_W-1:0];
        assign rem_in[l] = DV_REM_W'(pnum_q[l][NUM_W-1:QUO_W]);
      end
    end else begin : g_body
      assign v_in   = v_q[k-1];
      assign ds_in  = ds_q[k-1];
      assign quo_in = quo_q[k-1];
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
    end

    always_comb begin
      logic [DV_REM_W-1:0] rs, den;
      logic                ge;
      den = {1'b0, ds_in.root, 1'b0};
      for (int l = 0; l < LANES; l++) begin
        rs       = {rem_in[l][DEN_W-1:0], num_in[l][QUO_W-1]};
        ge       = (rs >= den);
        rem_d[l] = ge ? (rs - den) : rs;
        quo_d[l] = {quo_in[l][QUO_W-2:0], ge};
        num_d[l] = num_in[l] << 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= num_d;
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        ds_q[k]  <= ds_in;
      end
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign dside_o = ds_q[QUO_W-1];

endmodule

@@ design/rmq_out.sv @@
// ----------------------------------------------------------------------------
// rmq_out
// Merge the pivot component, sign, saturate, zero degenerates, register.
// ----------------------------------------------------------------------------
module rmq_out import rmq_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [LANES-1:0][QUO_W-1:0]  quo_i,
  input  rmq_dside_t                   dside_i,
  output logic                         valid_o,
  output rmq_out_t                     data_o
);

  localparam logic signed [CMP_W-1:0] POS_LIM = CMP_W'(32767);
  localparam logic signed [CMP_W-1:0] NEG_LIM = -CMP_W'(32768);

  logic [LANES-1:0][FIELD_W-1:0] qv;
  rmq_out_t                      data_d, data_q;
  logic                          valid_q;

  always_comb begin
    logic [CMP_W-1:0]        mag, lim;
    logic signed [CMP_W-1:0] sv;
    for (int l = 0; l < LANES; l++) begin
      if (dside_i.sel == slot_e'(l)) begin
        mag = (CMP_W'(dside_i.root) + CMP_W'(1)) >> 1;
      end else begin
        mag = CMP_W'(quo_i[l]);
      end
      lim = (mag > CMP_W'(ONE_Q)) ? CMP_W'(ONE_Q) : mag;
      sv  = dside_i.neg[l] ? -$signed(lim) : $signed(lim);
      priority if (sv > POS_LIM) begin
        sv = POS_LIM;
      end else if (sv < NEG_LIM) begin
        sv = NEG_LIM;
      end
      qv[l] = dside_i.deg ? '0 : sv[FIELD_W-1:0];
    end
    data_d.q_w        = qv[0];
    data_d.q_x        = qv[1];
    data_d.q_y        = qv[2];
    data_d.q_z        = qv[3];
    data_d.degenerate = dside_i.deg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ design/rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Format: components are Q1.14 on both channels.
// Throughput: one item per cycle unless the output stalls; the 16-stage square
// root and 24-stage four-lane divider take a new operand each advancing cycle.
// Reset: asynchronous, active low; clears every stage valid bit, so the
// pipeline comes up empty and ready. No other state is kept between items.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rmq_in_t   in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rmq_out_t  out_data_o
);

  // Whole pipeline moves as one: advance unless the output register holds
  // an item that the sink is stalling. Nothing is dropped or repeated.
  logic adv;

  logic              f_valid;
  logic [RAD_W-1:0]  f_rad;
  rmq_side_t         f_side;

  logic              s_valid;
  logic [ROOT_W-1:0] s_root;
  rmq_side_t         s_side;

  logic                        d_valid;
  logic [LANES-1:0][QUO_W-1:0] d_quo;
  rmq_dside_t                  d_side;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Stage 1: trace, pivot selection, radicand and off-diagonal terms.
  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (f_valid),
    .rad_o   (f_rad),
    .side_o  (f_side)
  );

  // Root of arg * ONE, one bit per stage.
  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (f_valid),
    .rad_i   (f_rad),
    .side_i  (f_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  // Rounded D * ONE / (2 * root) on four lanes; the pivot lane is unused.
  rmq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_valid),
    .root_i  (s_root),
    .side_i  (s_side),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .dside_o (d_side)
  );

  // Pivot component from the root, sign, clamp to +-ONE, degenerate zeroing.
  rmq_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (d_valid),
    .quo_i   (d_quo),
    .dside_i (d_side),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

@@ design/rmq_checker.sv @@
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
module rmq_checker import rmq_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input rmq_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input rmq_out_t out_data_o
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output item changed");

  // input stall only comes from output backpressure
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // degenerate items carry zeros
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.q_w == '0 && out_data_o.q_x == '0 &&
      out_data_o.q_y == '0 && out_data_o.q_z == '0)
    else $error("degenerate item with nonzero components");

  // components are saturated to plus or minus one
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.q_w <= 16'sd16384 && out_data_o.q_w >= -16'sd16384 &&
      out_data_o.q_x <= 16'sd16384 && out_data_o.q_x >= -16'sd16384 &&
      out_data_o.q_y <= 16'sd16384 && out_data_o.q_y >= -16'sd16384 &&
      out_data_o.q_z <= 16'sd16384 && out_data_o.q_z >= -16'sd16384)
    else $error("component outside saturation range");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);

@@ test/rmq_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rmq_scoreboard
// Watches both channels of the matrix to quaternion block, computes the
// quaternion for every accepted matrix and compares it with the output.
// ----------------------------------------------------------------------------
module rmq_scoreboard import rmq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  rmq_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  rmq_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o,
  output int       quat_count_o,
  output int       degen_count_o
);

  rmq_out_t quat_queue[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint sat_q(longint v);
    if (v > ONE_Q) v = ONE_Q;
    if (v < -ONE_Q) v = -ONE_Q;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic longint div_round(longint d, longint unsigned root);
    longint unsigned mag, quo;
    mag = (d < 0) ? longint'(-d) : d;
    quo = ((mag << FRAC_BITS) + root) / (root << 1);
    return (d < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic rmq_out_t matrix_to_quat(rmq_in_t a);
    longint m[3][3];
    longint q[4];
    longint tr, arg;
    longint unsigned root;
    int i, j, k;
    rmq_out_t r;
    m[0][0] = longint'(a.xa_x); m[1][0] = longint'(a.xa_y); m[2][0] = longint'(a.xa_z);
    m[0][1] = longint'(a.ya_x); m[1][1] = longint'(a.ya_y); m[2][1] = longint'(a.ya_z);
    m[0][2] = longint'(a.za_x); m[1][2] = longint'(a.za_y); m[2][2] = longint'(a.za_z);
    r = '0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      arg = tr + ONE_Q;
      root = int_sqrt(longint'(arg) << FRAC_BITS);
      q[0] = longint'((root + 1) >> 1);
      q[1] = div_round(m[2][1] - m[1][2], root);
      q[2] = div_round(m[0][2] - m[2][0], root);
      q[3] = div_round(m[1][0] - m[0][1], root);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      arg = m[i][i] - m[j][j] - m[k][k] + ONE_Q;
      if (arg <= 0) begin
        r.degenerate = 1'b1;
        return r;
      end
      root = int_sqrt(longint'(arg) << FRAC_BITS);
      q[1 + i] = longint'((root + 1) >> 1);
      q[0] = div_round(m[k][j] - m[j][k], root);
      q[1 + j] = div_round(m[j][i] + m[i][j], root);
      q[1 + k] = div_round(m[k][i] + m[i][k], root);
    end
    r.q_w = FIELD_W'(sat_q(q[0]));
    r.q_x = FIELD_W'(sat_q(q[1]));
    r.q_y = FIELD_W'(sat_q(q[2]));
    r.q_z = FIELD_W'(sat_q(q[3]));
    return r;
  endfunction

  assign pending_o = quat_queue.size();

  always @(posedge clk_i) begin
    rmq_out_t want;
    if (!rst_ni) begin
      quat_queue.delete();
      fail_count_o = 0;
      quat_count_o = 0;
      degen_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) quat_queue.push_back(matrix_to_quat(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (quat_queue.size() == 0) begin
          $error("output item with nothing expected");
          fail_count_o++;
        end else begin
          want = quat_queue.pop_front();
          quat_count_o++;
          if (want.degenerate) degen_count_o++;
          if (out_data_i.q_w !== want.q_w) begin
            $error("q_w expected %0d actual %0d", want.q_w, out_data_i.q_w);
            fail_count_o++;
          end
          if (out_data_i.q_x !== want.q_x) begin
            $error("q_x expected %0d actual %0d", want.q_x, out_data_i.q_x);
            fail_count_o++;
          end
          if (out_data_i.q_y !== want.q_y) begin
            $error("q_y expected %0d actual %0d", want.q_y, out_data_i.q_y);
            fail_count_o++;
          end
          if (out_data_i.q_z !== want.q_z) begin
            $error("q_z expected %0d actual %0d", want.q_z, out_data_i.q_z);
            fail_count_o++;
          end
          if (out_data_i.degenerate !== want.degenerate) begin
            $error("degenerate expected %0b actual %0b", want.degenerate,
                   out_data_i.degenerate);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

@@ test/rotation_matrix_to_quaternion_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Feeds directed and random matrices (proper rotations, near rotations and
// raw bit patterns) with random idling on both sides; a checker compares.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  localparam int NUM_RANDOM = 750;
  localparam int LATENCY    = 43;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  rmq_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  rmq_out_t out_data_o;
  int       fail_count, pending, quat_count, degen_count;
  bit       calm_phase;   // last part of the run: no idling

  rotation_matrix_to_quaternion u_top (.*);

  rmq_scoreboard u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .quat_count_o(quat_count), .degen_count_o(degen_count)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Build a matrix from nine entries, column by column.
  function automatic rmq_in_t make_matrix(int e0, int e1, int e2, int e3, int e4,
                                          int e5, int e6, int e7, int e8);
    rmq_in_t a;
    a.xa_x = FIELD_W'(e0); a.xa_y = FIELD_W'(e1); a.xa_z = FIELD_W'(e2);
    a.ya_x = FIELD_W'(e3); a.ya_y = FIELD_W'(e4); a.ya_z = FIELD_W'(e5);
    a.za_x = FIELD_W'(e6); a.za_y = FIELD_W'(e7); a.za_z = FIELD_W'(e8);
    return a;
  endfunction

  function automatic int rand_q();
    return $urandom_range(2 * ONE_Q) - ONE_Q;
  endfunction

  // Rotation by a random angle about one axis, possibly with axes permuted
  // and signs flipped so every branch of the selection gets exercised.
  function automatic rmq_in_t rand_rotation();
    real ang, c, s;
    int ci, si, sel;
    ang = ($urandom % 62832) / 10000.0;
    c = $cos(ang);
    s = $sin(ang);
    ci = $rtoi(c * ONE_Q);
    si = $rtoi(s * ONE_Q);
    sel = $urandom_range(5);
    case (sel)
      0: return make_matrix(ONE_Q, 0, 0, 0, ci, si, 0, -si, ci);
      1: return make_matrix(ci, 0, -si, 0, ONE_Q, 0, si, 0, ci);
      2: return make_matrix(ci, si, 0, -si, ci, 0, 0, 0, ONE_Q);
      3: return make_matrix(-ONE_Q, 0, 0, 0, ci, si, 0, si, -ci);
      4: return make_matrix(ci, si, 0, si, -ci, 0, 0, 0, -ONE_Q);
      default: begin
        // small random perturbation of an x-axis rotation
        return make_matrix(ONE_Q - $urandom_range(40), $urandom_range(80) - 40,
                           $urandom_range(80) - 40, $urandom_range(80) - 40,
                           ci, si, $urandom_range(80) - 40, -si, ci);
      end
    endcase
  endfunction

  function automatic rmq_in_t rand_matrix();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return rand_rotation();
    if (pick < 85)
      return make_matrix(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                         rand_q(), rand_q(), rand_q(), rand_q());
    // raw bit patterns reach every bit of every field
    return rmq_in_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
  endfunction

  // Offer one item; hold it until accepted.
  task automatic send_item(rmq_in_t a, bit allow_gap);
    int gap;
    if (allow_gap && !calm_phase && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= a;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Receiver: random stall bursts, one long hold-off to fill the pipeline.
  initial begin
    int burst;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    repeat (30) @(posedge clk_i);
    // hold off long enough to back up into the input
    out_stall_i <= 1'b1;
    repeat (200) @(posedge clk_i);
    out_stall_i <= 1'b0;
    while (!calm_phase) begin
      if ($urandom_range(2) == 0) begin
        burst = $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    out_stall_i <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rmq_in_t directed[$];
    int drain;
    in_valid_i = 1'b0;
    in_data_i = '0;
    calm_phase = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity and extremes
    directed.push_back(make_matrix(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q));
    directed.push_back(make_matrix(ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q,
                                   ONE_Q, ONE_Q, ONE_Q));
    directed.push_back(make_matrix(-ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q,
                                   -ONE_Q, -ONE_Q, -ONE_Q));
    directed.push_back(make_matrix(ONE_Q, -ONE_Q, ONE_Q, ONE_Q, ONE_Q, -ONE_Q,
                                   -ONE_Q, ONE_Q, ONE_Q));
    // 180 degree turns: each diagonal entry picked first
    directed.push_back(make_matrix(ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
    directed.push_back(make_matrix(-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q));
    directed.push_back(make_matrix(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q));
    // diagonal ties go to the lower index
    directed.push_back(make_matrix(0, 100, 200, 300, 0, 400, 500, 600, -ONE_Q));
    directed.push_back(make_matrix(-8192, 5, 7, 9, -8192, 11, 13, 17, -8192));
    directed.push_back(make_matrix(-ONE_Q, 1, 2, 3, 0, 4, 5, 6, 0));
    // zero matrix and negated identity: trace not positive
    directed.push_back(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_matrix(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
    // trace just positive, and negative trace with big off-diagonals
    directed.push_back(make_matrix(1, ONE_Q, -ONE_Q, -ONE_Q, 0, ONE_Q, ONE_Q, -ONE_Q, 0));
    directed.push_back(make_matrix(-ONE_Q + 1, ONE_Q, ONE_Q, ONE_Q, -ONE_Q + 1,
                                   ONE_Q, ONE_Q, ONE_Q, -ONE_Q + 1));
    // full-range raw patterns
    directed.push_back(make_matrix(32767, 32767, 32767, 32767, 32767, 32767,
                                   32767, 32767, 32767));
    directed.push_back(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768));
    directed.push_back(make_matrix(32767, -32768, 32767, -32768, -32768, 32767,
                                   -32768, 32767, -32768));
    directed.push_back(make_matrix(-32768, 32767, -32768, 32767, 32767, -32768,
                                   32767, -32768, 32767));
    directed.push_back(rmq_in_t'({144{1'b1}}));
    foreach (directed[n]) send_item(directed[n], 1'b1);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - 100) calm_phase = 1'b1;
      send_item(rand_matrix(), 1'b1);
    end
    in_valid_i <= 1'b0;

    drain = 0;
    while (pending != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Covered %0d quaternions (%0d degenerate) from directed and random matrices",
             quat_count, degen_count);
    $display("under random idling on both sides and one long output hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (pending != 0) $error("%0d expected items never arrived", pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
